// File: hw/rtl/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

  localparam int unsigned StackDepth = 64;
  localparam int unsigned DataWidth  = 32;
  localparam int unsigned AddrWidth  = $clog2(StackDepth);
  localparam int unsigned CountWidth = $clog2(StackDepth + 1);
  localparam int unsigned FillWidth  = 7;
  localparam int unsigned StatWidth  = 2;

  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  localparam logic [StatWidth-1:0] StatusOk        = 2'd0;
  localparam logic [StatWidth-1:0] StatusUnderflow = 2'd1;
  localparam logic [StatWidth-1:0] StatusOverflow  = 2'd2;

  typedef struct packed {
    logic                        opcode;
    logic signed [DataWidth-1:0] push_value;
  } mts_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] popped_value;
    logic signed [DataWidth-1:0] max_value;
    logic                        max_valid;
    logic [FillWidth-1:0]        fill_count;
    logic [StatWidth-1:0]        status;
  } mts_out_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;    // input transfer this cycle
    logic reload;  // refill top registers after a pop
  } mts_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pop_ok;  // offered item is a pop on a non-empty stack
  } mts_sts_t;

endpackage

// File: hw/rtl/max_tracking_stack.sv
`timescale 1ns / 1ps
// Bounded LIFO stack of signed words that also reports its largest entry.
// Input channel (in_valid_i/in_ready_o, in_data_i): opcode 0 pushes push_value,
// opcode 1 pops the top. Output channel (out_valid_o/out_ready_i, out_data_o):
// exactly one result per input transfer, in order, carrying the popped word,
// the current maximum with its valid flag, the fill count and a status code
// (ok, underflow on an empty pop, overflow on a full push; errors change nothing).
// A push or an erroring operation shows its result in the cycle after the
// transfer; a successful pop passes through the Reload state while the new top
// of both stacks comes back from a registered memory read before the result is
// built. Pushes go at one per cycle while results drain; Reload blocks input.
// A single output register holds the result; the next item is taken in the
// same cycle that the receiver takes the pending result, and the block stalls
// its input while a result waits and out_ready_i stays low.
// Reset empties both stacks at once (depth counters only, no clearing pass);
// memory contents are undefined until written; reads of them are never used.
module max_tracking_stack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mts_pkg::mts_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mts_pkg::mts_out_t out_data_o
);
  import mts_pkg::*;

  mts_cmd_t cmd;
  mts_sts_t sts;

  mts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mts_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: hw/rtl/mts_ctrl.sv
`timescale 1ns / 1ps

module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  mts_pkg::mts_sts_t sts_i,
  output mts_pkg::mts_cmd_t cmd_o
);
  import mts_pkg::*;

  typedef enum logic {
    Idle,
    Reload
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   exec;

  assign in_ready_o  = (state_q == Idle) && (!out_valid_q || out_ready_i);
  assign exec        = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.exec   = exec;
  assign cmd_o.reload = (state_q == Reload);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        Idle: begin
          if (exec && sts_i.pop_ok) begin
            state_q <= Reload;
          end
        end
        Reload: begin
          state_q <= Idle;
        end
        default: begin
          state_q <= Idle;
        end
      endcase
      if ((exec && !sts_i.pop_ok) || (state_q == Reload)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_reload_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Reload) |-> $past(exec && sts_i.pop_ok))
    else $error("reload without a preceding pop");

  a_reload_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Reload) |-> !out_valid_q)
    else $error("result slot busy during reload");

  a_reload_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Reload) |=> out_valid_q)
    else $error("pop produced no result");
`endif

endmodule

// File: hw/rtl/mts_dpath.sv
`timescale 1ns / 1ps

module mts_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mts_pkg::mts_in_t  in_data_i,
  input  mts_pkg::mts_cmd_t cmd_i,
  output mts_pkg::mts_sts_t sts_o,
  output mts_pkg::mts_out_t out_data_o
);
  import mts_pkg::*;

  logic [DataWidth-1:0] val_mem [StackDepth];
  logic [DataWidth-1:0] max_mem [StackDepth];

  logic [CountWidth-1:0]       vdepth_q, mdepth_q;
  logic signed [DataWidth-1:0] vtop_q, mtop_q;
  logic signed [DataWidth-1:0] rd_val_q, rd_max_q;
  logic                        pop_max_q;
  mts_out_t                    out_q;

  logic                        is_push, is_pop, full, empty, pop_ok, push_ok, push_max;
  logic signed [DataWidth-1:0] cur_max, new_max;
  logic [AddrWidth-1:0]        rd_val_addr, rd_max_addr;

  assign is_push  = (in_data_i.opcode == OpPush);
  assign is_pop   = (in_data_i.opcode == OpPop);
  assign full     = (vdepth_q == CountWidth'(StackDepth));
  assign empty    = (vdepth_q == '0);
  assign pop_ok   = is_pop && !empty;
  assign push_ok  = is_push && !full;
  assign push_max = (mdepth_q == '0) || ($signed(in_data_i.push_value) >= mtop_q);
  assign cur_max  = empty ? '0 : mtop_q;
  assign new_max  = push_max ? in_data_i.push_value : mtop_q;

  assign rd_val_addr = vdepth_q[AddrWidth-1:0] - AddrWidth'(2);
  assign rd_max_addr = mdepth_q[AddrWidth-1:0] - AddrWidth'(2);

  assign sts_o.pop_ok = pop_ok;
  assign out_data_o   = out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      val_mem[vdepth_q[AddrWidth-1:0]] <= in_data_i.push_value;
      if (push_max) begin
        max_mem[mdepth_q[AddrWidth-1:0]] <= in_data_i.push_value;
      end
    end
    if (cmd_i.exec) begin
      rd_val_q <= val_mem[rd_val_addr];
      rd_max_q <= max_mem[rd_max_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vdepth_q <= '0;
      mdepth_q <= '0;
    end else if (cmd_i.exec) begin
      if (push_ok) begin
        vdepth_q <= vdepth_q + CountWidth'(1);
        if (push_max) begin
          mdepth_q <= mdepth_q + CountWidth'(1);
        end
      end else if (pop_ok) begin
        vdepth_q <= vdepth_q - CountWidth'(1);
        if (vtop_q == mtop_q) begin
          mdepth_q <= mdepth_q - CountWidth'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (push_ok) begin
        vtop_q <= in_data_i.push_value;
        if (push_max) begin
          mtop_q <= in_data_i.push_value;
        end
        out_q.popped_value <= '0;
        out_q.max_value    <= new_max;
        out_q.max_valid    <= 1'b1;
        out_q.fill_count   <= FillWidth'(vdepth_q + CountWidth'(1));
        out_q.status       <= StatusOk;
      end else if (pop_ok) begin
        pop_max_q          <= (vtop_q == mtop_q);
        out_q.popped_value <= vtop_q;
        out_q.fill_count   <= FillWidth'(vdepth_q - CountWidth'(1));
        out_q.status       <= StatusOk;
      end else begin
        out_q.popped_value <= '0;
        out_q.max_value    <= cur_max;
        out_q.max_valid    <= !empty;
        out_q.fill_count   <= FillWidth'(vdepth_q);
        out_q.status       <= is_push ? StatusOverflow : StatusUnderflow;
      end
    end else if (cmd_i.reload) begin
      vtop_q <= rd_val_q;
      if (pop_max_q) begin
        mtop_q <= rd_max_q;
      end
      out_q.max_valid <= !empty;
      if (empty) begin
        out_q.max_value <= '0;
      end else if (pop_max_q) begin
        out_q.max_value <= rd_max_q;
      end else begin
        out_q.max_value <= mtop_q;
      end
    end
  end

`ifndef SYNTH
  a_max_not_deeper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdepth_q <= vdepth_q)
    else $error("maxima stack deeper than value stack");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vdepth_q <= CountWidth'(StackDepth))
    else $error("value depth out of range");

  a_empty_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vdepth_q == '0) == (mdepth_q == '0))
    else $error("maxima stack empty state disagrees with value stack");
`endif

endmodule

// File: tb/max_tracking_stack_chk.sv
`timescale 1ns / 1ps

module max_tracking_stack_chk
  import mts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_ready_i,
  input  mts_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_ready_i,
  input  mts_out_t out_data_i,
  output int       mismatches_o,
  output int       pending_o,
  output int       results_o,
  output int       underflows_o,
  output int       overflows_o
);

  logic signed [DataWidth-1:0] word_stack [StackDepth];
  logic signed [DataWidth-1:0] peak_stack [StackDepth];
  int unsigned word_depth;
  int unsigned peak_depth;
  mts_out_t    owed_results [$];
  int          mismatches;
  int          results;
  int          underflows;
  int          overflows;

  function automatic mts_out_t apply_stack_op(mts_in_t item);
    mts_out_t res;
    res = '0;
    res.status = StatusOk;
    if (item.opcode == OpPush) begin
      if (word_depth >= StackDepth) begin
        res.status = StatusOverflow;
      end else begin
        word_stack[word_depth] = item.push_value;
        word_depth++;
        if (peak_depth == 0 || item.push_value >= peak_stack[peak_depth-1]) begin
          peak_stack[peak_depth] = item.push_value;
          peak_depth++;
        end
      end
    end else begin
      if (word_depth == 0) begin
        res.status = StatusUnderflow;
      end else begin
        word_depth--;
        res.popped_value = word_stack[word_depth];
        if (peak_depth > 0 && res.popped_value == peak_stack[peak_depth-1]) begin
          peak_depth--;
        end
      end
    end
    if (peak_depth > 0 && word_depth > 0) begin
      res.max_value = peak_stack[peak_depth-1];
      res.max_valid = 1'b1;
    end
    res.fill_count = FillWidth'(word_depth);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mts_out_t want;
    if (!rst_ni) begin
      word_depth = 0;
      peak_depth = 0;
      owed_results.delete();
      mismatches = 0;
      results = 0;
      underflows = 0;
      overflows = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results++;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: unexpected transfer, popped=%0d max=%0d valid=%0b fill=%0d st=%0d",
                     results, out_data_i.popped_value, out_data_i.max_value,
                     out_data_i.max_valid, out_data_i.fill_count, out_data_i.status);
          end
        end else begin
          want = owed_results.pop_front();
          if (out_data_i.popped_value !== want.popped_value ||
              out_data_i.max_value !== want.max_value ||
              out_data_i.max_valid !== want.max_valid ||
              out_data_i.fill_count !== want.fill_count ||
              out_data_i.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: exp popped=%0d max=%0d valid=%0b fill=%0d st=%0d",
                       results, want.popped_value, want.max_value, want.max_valid,
                       want.fill_count, want.status);
              $display("result %0d: got popped=%0d max=%0d valid=%0b fill=%0d st=%0d",
                       results, out_data_i.popped_value, out_data_i.max_value,
                       out_data_i.max_valid, out_data_i.fill_count, out_data_i.status);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = apply_stack_op(in_data_i);
        if (want.status == StatusUnderflow) underflows++;
        if (want.status == StatusOverflow) overflows++;
        owed_results.push_back(want);
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= owed_results.size();
    results_o    <= results;
    underflows_o <= underflows;
    overflows_o  <= overflows;
  end

endmodule

// File: tb/max_tracking_stack_tb.sv
`timescale 1ns / 1ps

module max_tracking_stack_tb;
  import mts_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int RandomItems = 1200;

  logic     clk_i;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  mts_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  mts_out_t out_data;

  int mismatches;
  int pending;
  int results;
  int underflows;
  int overflows;
  int cycles = 0;
  int pushes = 0;
  int pops = 0;
  logic calm = 1'b0;

  max_tracking_stack u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  max_tracking_stack_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .results_o   (results),
    .underflows_o(underflows),
    .overflows_o (overflows)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  function automatic logic signed [DataWidth-1:0] pick_word();
    logic signed [DataWidth-1:0] w;
    case ($urandom_range(0, 9))
      0: w = {1'b0, {(DataWidth-1){1'b1}}};
      1: w = {1'b1, {(DataWidth-1){1'b0}}};
      2, 3, 4, 5: w = DataWidth'($urandom_range(0, 16)) - DataWidth'(8);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // valid stays high back to back unless an idle gap is drawn
  task automatic send_op(input logic op, input logic signed [DataWidth-1:0] val);
    if (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= mts_in_t'{opcode: op, push_value: val};
    do @(posedge clk_i); while (!in_ready);
    if (op == OpPush) pushes++;
    else pops++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int sent;
    int burst_len;
    int push_pct;
    int kind;
    bit paused;
    sent = 0;
    paused = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops, extremes, equal maxima, drain to empty
    send_op(OpPop, $urandom);
    send_op(OpPush, {1'b0, {(DataWidth-1){1'b1}}});
    send_op(OpPush, {1'b1, {(DataWidth-1){1'b0}}});
    send_op(OpPush, '0);
    send_op(OpPush, '1);
    send_op(OpPush, {1'b0, {(DataWidth-1){1'b1}}});
    repeat (5) send_op(OpPop, $urandom);
    send_op(OpPop, '1);
    send_op(OpPush, {1'b1, {(DataWidth-1){1'b0}}});
    send_op(OpPush, {1'b1, {(DataWidth-1){1'b0}}});
    send_op(OpPop, '0);
    send_op(OpPush, DataWidth'(5));
    send_op(OpPush, DataWidth'(3));
    send_op(OpPush, DataWidth'(5));
    repeat (5) send_op(OpPop, $urandom);

    while (sent < RandomItems) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin burst_len = StackDepth + 6; push_pct = 100; end
        1: begin burst_len = StackDepth + 4; push_pct = 0; end
        2, 3, 4: begin burst_len = $urandom_range(20, 100); push_pct = 85; end
        5, 6: begin burst_len = $urandom_range(20, 100); push_pct = 15; end
        default: begin burst_len = $urandom_range(10, 60); push_pct = 50; end
      endcase
      repeat (burst_len) begin
        calm = (sent >= 300 && sent < 500);
        if ($urandom_range(0, 99) < push_pct) send_op(OpPush, pick_word());
        else send_op(OpPop, $urandom);
        sent++;
      end
      if (!paused && sent >= 700) begin
        paused = 1'b1;
        drain_results();
        repeat ($urandom_range(3, 12)) @(posedge clk_i);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("sent %0d pushes and %0d pops, %0d results checked", pushes, pops, results);
    $display("error cases hit: %0d underflow, %0d overflow", underflows, overflows);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
